FILE: rtl/tgr_pkg.sv
// Package for the touch gesture recognizer: codes, configuration types, reset values.
`default_nettype none

package tgr_pkg;

    // Fixed field widths
    localparam int ID_BITS        = 4;
    localparam int SLOP_BITS      = 12;
    localparam int DUR_BITS       = 16;
    localparam int CFG_ADDR_BITS  = 3;
    localparam int CFG_DATA_BITS  = 16;

    // Event kinds on the input channel
    typedef enum logic [1:0] {
        OP_DOWN = 2'd0,
        OP_MOVE = 2'd1,
        OP_UP   = 2'd2,
        OP_TICK = 2'd3
    } op_t;

    // Gesture kinds on the result channel
    typedef enum logic [1:0] {
        KIND_SWIPE  = 2'd0,
        KIND_TAP    = 2'd1,
        KIND_DOUBLE = 2'd2,
        KIND_HOLD   = 2'd3
    } kind_t;

    // Configuration register indexes
    typedef enum logic [CFG_ADDR_BITS-1:0] {
        CFG_TAP_SLOP    = 3'd0,
        CFG_SWIPE_LEN   = 3'd1,
        CFG_TAP_TIMEOUT = 3'd2,
        CFG_DTAP_WINDOW = 3'd3,
        CFG_HOLD_TIME   = 3'd4
    } cfg_addr_t;

    // Register reset values
    localparam logic [SLOP_BITS-1:0] TAP_SLOP_RST    = 12'd20;
    localparam logic [SLOP_BITS-1:0] SWIPE_LEN_RST   = 12'd60;
    localparam logic [DUR_BITS-1:0]  TAP_TIMEOUT_RST = 16'd350;
    localparam logic [DUR_BITS-1:0]  DTAP_WINDOW_RST = 16'd450;
    localparam logic [DUR_BITS-1:0]  HOLD_TIME_RST   = 16'd650;

    // Thresholds as seen by the recognizer core
    typedef struct packed {
        logic [SLOP_BITS-1:0] tap_slop;
        logic [SLOP_BITS-1:0] swipe_len;
        logic [DUR_BITS-1:0]  tap_timeout;
        logic [DUR_BITS-1:0]  double_tap_window;
        logic [DUR_BITS-1:0]  hold_time;
    } cfg_t;

endpackage

`default_nettype wire

FILE: rtl/tgr_cfg_regs.sv
// Configuration register file for the touch gesture recognizer.
`default_nettype none

module tgr_cfg_regs
    import tgr_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     cfg_we,
    input  wire logic [CFG_ADDR_BITS-1:0] cfg_addr,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_wdata,
    output cfg_t                          cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write; indexes past the list are dropped
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_addr)
                CFG_TAP_SLOP:    cfg_next.tap_slop          = cfg_wdata[SLOP_BITS-1:0];
                CFG_SWIPE_LEN:   cfg_next.swipe_len         = cfg_wdata[SLOP_BITS-1:0];
                CFG_TAP_TIMEOUT: cfg_next.tap_timeout       = cfg_wdata[DUR_BITS-1:0];
                CFG_DTAP_WINDOW: cfg_next.double_tap_window = cfg_wdata[DUR_BITS-1:0];
                CFG_HOLD_TIME:   cfg_next.hold_time         = cfg_wdata[DUR_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.tap_slop          <= TAP_SLOP_RST;
            cfg_reg.swipe_len         <= SWIPE_LEN_RST;
            cfg_reg.tap_timeout       <= TAP_TIMEOUT_RST;
            cfg_reg.double_tap_window <= DTAP_WINDOW_RST;
            cfg_reg.hold_time         <= HOLD_TIME_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

FILE: rtl/tgr_core.sv
// Gesture state and decision logic: one event evaluated and applied per cycle in which fire is high.
`default_nettype none

module tgr_core
    import tgr_pkg::*;
#(
    parameter int COORD_BITS    = 12,
    parameter int CONTACT_COUNT = 16,
    parameter int TIME_BITS     = 32
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire cfg_t                  cfg,
    input  wire logic                  fire,
    input  wire op_t                   op,
    input  wire logic [ID_BITS-1:0]    contact_id,
    input  wire logic [COORD_BITS-1:0] pos_x,
    input  wire logic [COORD_BITS-1:0] pos_y,
    input  wire logic [TIME_BITS-1:0]  now_ms,
    output logic                       res_valid,
    output kind_t                      res_kind,
    output logic [ID_BITS-1:0]         res_id,
    output logic [COORD_BITS-1:0]      res_end_x,
    output logic [COORD_BITS-1:0]      res_end_y,
    output logic [COORD_BITS-1:0]      res_begin_x,
    output logic [COORD_BITS-1:0]      res_begin_y,
    output logic [COORD_BITS:0]        res_delta_x,
    output logic [COORD_BITS:0]        res_delta_y
);

    // Compare width covering both coordinates and twice the slop
    localparam int DW = ((COORD_BITS > SLOP_BITS) ? COORD_BITS : SLOP_BITS) + 1;

    function automatic logic [COORD_BITS-1:0] abs_diff(
        input logic [COORD_BITS-1:0] a,
        input logic [COORD_BITS-1:0] b
    );
        abs_diff = (a > b) ? (a - b) : (b - a);
    endfunction

    function automatic logic [DW-1:0] cheb(
        input logic [COORD_BITS-1:0] ax,
        input logic [COORD_BITS-1:0] ay,
        input logic [COORD_BITS-1:0] bx,
        input logic [COORD_BITS-1:0] by
    );
        logic [COORD_BITS-1:0] dx;
        logic [COORD_BITS-1:0] dy;
        dx   = abs_diff(ax, bx);
        dy   = abs_diff(ay, by);
        cheb = DW'((dx > dy) ? dx : dy);
    endfunction

    // Gesture state
    logic                  pressed_reg,        pressed_next;
    logic                  hold_reported_reg,  hold_reported_next;
    logic [ID_BITS-1:0]    owner_reg,          owner_next;
    logic [COORD_BITS-1:0] origin_x_reg,       origin_x_next;
    logic [COORD_BITS-1:0] origin_y_reg,       origin_y_next;
    logic [COORD_BITS-1:0] latest_x_reg,       latest_x_next;
    logic [COORD_BITS-1:0] latest_y_reg,       latest_y_next;
    logic [TIME_BITS-1:0]  press_time_reg,     press_time_next;
    logic [TIME_BITS-1:0]  prior_tap_time_reg, prior_tap_time_next;
    logic [COORD_BITS-1:0] prior_tap_x_reg,    prior_tap_x_next;
    logic [COORD_BITS-1:0] prior_tap_y_reg,    prior_tap_y_next;

    // Distances and elapsed times
    logic                 id_ok;
    logic                 owns;
    logic [DW-1:0]        dist_up;
    logic [DW-1:0]        dist_hold;
    logic [DW-1:0]        dist_prior;
    logic [DW-1:0]        slop_w;
    logic [DW-1:0]        slop2_w;
    logic [DW-1:0]        swipe_w;
    logic [TIME_BITS-1:0] since_press;
    logic [TIME_BITS-1:0] since_tap;
    logic                 is_swipe;
    logic                 is_tap;
    logic                 is_double;
    logic                 is_hold;

    assign id_ok       = 32'(contact_id) < CONTACT_COUNT;
    assign owns        = pressed_reg && (owner_reg == contact_id);
    assign dist_up     = cheb(origin_x_reg, origin_y_reg, pos_x, pos_y);
    assign dist_hold   = cheb(origin_x_reg, origin_y_reg, latest_x_reg, latest_y_reg);
    assign dist_prior  = cheb(prior_tap_x_reg, prior_tap_y_reg, pos_x, pos_y);
    assign slop_w      = DW'(cfg.tap_slop);
    assign slop2_w     = slop_w << 1;
    assign swipe_w     = DW'(cfg.swipe_len);
    assign since_press = now_ms - press_time_reg;
    assign since_tap   = now_ms - prior_tap_time_reg;

    // Classification of an up from the owner, and of a tick
    assign is_swipe  = dist_up >= swipe_w;
    assign is_tap    = !is_swipe && !hold_reported_reg && (dist_up <= slop_w)
                    && (since_press <= TIME_BITS'(cfg.tap_timeout));
    assign is_double = (prior_tap_time_reg != '0)
                    && (since_tap <= TIME_BITS'(cfg.double_tap_window))
                    && (dist_prior <= slop2_w);
    assign is_hold   = pressed_reg && !hold_reported_reg
                    && (since_press >= TIME_BITS'(cfg.hold_time))
                    && (dist_hold <= slop_w);

    // Result and next state
    always_comb begin
        pressed_next        = pressed_reg;
        hold_reported_next  = hold_reported_reg;
        owner_next          = owner_reg;
        origin_x_next       = origin_x_reg;
        origin_y_next       = origin_y_reg;
        latest_x_next       = latest_x_reg;
        latest_y_next       = latest_y_reg;
        press_time_next     = press_time_reg;
        prior_tap_time_next = prior_tap_time_reg;
        prior_tap_x_next    = prior_tap_x_reg;
        prior_tap_y_next    = prior_tap_y_reg;

        res_valid   = 1'b0;
        res_kind    = KIND_SWIPE;
        res_id      = contact_id;
        res_end_x   = pos_x;
        res_end_y   = pos_y;
        res_begin_x = origin_x_reg;
        res_begin_y = origin_y_reg;
        res_delta_x = {1'b0, pos_x} - {1'b0, origin_x_reg};
        res_delta_y = {1'b0, pos_y} - {1'b0, origin_y_reg};

        if (fire) begin
            unique case (op)
                OP_DOWN: begin
                    if (id_ok && !pressed_reg) begin
                        pressed_next       = 1'b1;
                        hold_reported_next = 1'b0;
                        owner_next         = contact_id;
                        origin_x_next      = pos_x;
                        origin_y_next      = pos_y;
                        latest_x_next      = pos_x;
                        latest_y_next      = pos_y;
                        press_time_next    = now_ms;
                    end
                end
                OP_MOVE: begin
                    if (id_ok && owns) begin
                        latest_x_next = pos_x;
                        latest_y_next = pos_y;
                    end
                end
                OP_UP: begin
                    if (id_ok && owns) begin
                        latest_x_next      = pos_x;
                        latest_y_next      = pos_y;
                        pressed_next       = 1'b0;
                        hold_reported_next = 1'b0;
                        if (is_swipe) begin
                            res_valid = 1'b1;
                            res_kind  = KIND_SWIPE;
                        end else if (is_tap) begin
                            res_valid = 1'b1;
                            if (is_double) begin
                                res_kind            = KIND_DOUBLE;
                                prior_tap_time_next = '0;
                            end else begin
                                res_kind            = KIND_TAP;
                                prior_tap_time_next = now_ms;
                                prior_tap_x_next    = pos_x;
                                prior_tap_y_next    = pos_y;
                            end
                        end
                    end
                end
                OP_TICK: begin
                    if (is_hold) begin
                        res_valid          = 1'b1;
                        res_kind           = KIND_HOLD;
                        res_id             = owner_reg;
                        res_end_x          = latest_x_reg;
                        res_end_y          = latest_y_reg;
                        res_delta_x        = '0;
                        res_delta_y        = '0;
                        hold_reported_next = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pressed_reg        <= 1'b0;
            hold_reported_reg  <= 1'b0;
            owner_reg          <= '0;
            origin_x_reg       <= '0;
            origin_y_reg       <= '0;
            latest_x_reg       <= '0;
            latest_y_reg       <= '0;
            press_time_reg     <= '0;
            prior_tap_time_reg <= '0;
            prior_tap_x_reg    <= '0;
            prior_tap_y_reg    <= '0;
        end else begin
            pressed_reg        <= pressed_next;
            hold_reported_reg  <= hold_reported_next;
            owner_reg          <= owner_next;
            origin_x_reg       <= origin_x_next;
            origin_y_reg       <= origin_y_next;
            latest_x_reg       <= latest_x_next;
            latest_y_reg       <= latest_y_next;
            press_time_reg     <= press_time_next;
            prior_tap_time_reg <= prior_tap_time_next;
            prior_tap_x_reg    <= prior_tap_x_next;
            prior_tap_y_reg    <= prior_tap_y_next;
        end
    end

`ifndef NO_ASSERTIONS
    // An up from the owner always ends the press
    a_up_ends_press: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && op == OP_UP && owns |=> !pressed_reg && !hold_reported_reg)
        else $error("press not ended by owner up");

    // A hold is reported at most once per press
    a_hold_once: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && res_kind == KIND_HOLD |=> hold_reported_reg && pressed_reg)
        else $error("hold not marked as reported");

    // A double tap consumes the stored tap
    a_double_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && res_kind == KIND_DOUBLE |=> prior_tap_time_reg == '0)
        else $error("prior tap kept after double tap");
`endif

endmodule

`default_nettype wire

FILE: rtl/touch_gesture_recognizer.sv
// Touch gesture recognizer top level: event register, core and result register.
//
// Input stream: one touch event per beat. s_tuser carries the event kind
// (down, move, up, tick); s_tdata carries contact id, x, y and the ms time.
// Result stream: one gesture per beat (swipe, tap, double tap, hold), kind in
// m_tuser, the rest in m_tdata. Events that finish no gesture give no beat.
// An accepted event waits in the event register until the core evaluates it;
// its gesture is then registered in the result register that drives m_tvalid.
// Throughput: one event per cycle while the result register is not stalled;
// the gesture state is updated in the same cycle that evaluates an event, so
// events may follow back to back. When the receiver stalls, the result
// register holds its beat; the event register still takes one more event,
// then s_tready drops until the result is taken.
// Reset (aresetn low, synchronous) clears the gesture state, the stored
// tap and the valid flags of both pipeline registers, and loads the default
// thresholds. Thresholds are written through cfg_we/cfg_addr/cfg_wdata while
// idle; the user must keep to this, the block itself does not enforce it.
`default_nettype none

module touch_gesture_recognizer
    import tgr_pkg::*;
#(
    parameter int COORD_BITS    = 12,
    parameter int CONTACT_COUNT = 16,
    parameter int TIME_BITS     = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    // input channel
    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    // contact_id, pos_x, pos_y, now_ms (from bit 0), zero padded
    input  wire logic [((ID_BITS + 2 * COORD_BITS + TIME_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    // op
    input  wire logic [1:0]               s_tuser,
    // result channel
    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    // contact slot, end_x, end_y, begin_x, begin_y, delta_x, delta_y,
    // event_time (from bit 0), zero padded
    output logic [((ID_BITS + 6 * COORD_BITS + 2 + TIME_BITS + 7) / 8) * 8 - 1:0] m_tdata,
    // gesture_kind
    output logic [1:0]                    m_tuser,
    // configuration
    input  wire logic                     cfg_we,
    input  wire logic [CFG_ADDR_BITS-1:0] cfg_addr,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_wdata
);

    localparam int OUT_W  = ID_BITS + 4 * COORD_BITS + 2 * (COORD_BITS + 1) + TIME_BITS;
    localparam int OUT_DW = ((OUT_W + 7) / 8) * 8;

    cfg_t cfg;

    // Event register
    logic                  in_valid_reg;
    op_t                   in_op_reg;
    logic [ID_BITS-1:0]    in_id_reg;
    logic [COORD_BITS-1:0] in_x_reg;
    logic [COORD_BITS-1:0] in_y_reg;
    logic [TIME_BITS-1:0]  in_time_reg;

    // Result register
    logic                  out_valid_reg;
    kind_t                 out_kind_reg;
    logic [ID_BITS-1:0]    out_id_reg;
    logic [COORD_BITS-1:0] out_end_x_reg;
    logic [COORD_BITS-1:0] out_end_y_reg;
    logic [COORD_BITS-1:0] out_begin_x_reg;
    logic [COORD_BITS-1:0] out_begin_y_reg;
    logic [COORD_BITS:0]   out_delta_x_reg;
    logic [COORD_BITS:0]   out_delta_y_reg;
    logic [TIME_BITS-1:0]  out_time_reg;

    // Core results
    logic                  res_valid;
    kind_t                 res_kind;
    logic [ID_BITS-1:0]    res_id;
    logic [COORD_BITS-1:0] res_end_x;
    logic [COORD_BITS-1:0] res_end_y;
    logic [COORD_BITS-1:0] res_begin_x;
    logic [COORD_BITS-1:0] res_begin_y;
    logic [COORD_BITS:0]   res_delta_x;
    logic [COORD_BITS:0]   res_delta_y;

    logic advance;
    logic fire;
    logic s_beat;

    // Pipeline control
    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign s_beat   = s_tvalid && s_tready;

    tgr_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    tgr_core #(
        .COORD_BITS    (COORD_BITS),
        .CONTACT_COUNT (CONTACT_COUNT),
        .TIME_BITS     (TIME_BITS)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .fire        (fire),
        .op          (in_op_reg),
        .contact_id  (in_id_reg),
        .pos_x       (in_x_reg),
        .pos_y       (in_y_reg),
        .now_ms      (in_time_reg),
        .res_valid   (res_valid),
        .res_kind    (res_kind),
        .res_id      (res_id),
        .res_end_x   (res_end_x),
        .res_end_y   (res_end_y),
        .res_begin_x (res_begin_x),
        .res_begin_y (res_begin_y),
        .res_delta_x (res_delta_x),
        .res_delta_y (res_delta_y)
    );

    // Event register: control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    // Event register: payload
    always_ff @(posedge aclk) begin
        if (s_beat) begin
            in_op_reg   <= op_t'(s_tuser);
            in_id_reg   <= s_tdata[ID_BITS-1:0];
            in_x_reg    <= s_tdata[ID_BITS +: COORD_BITS];
            in_y_reg    <= s_tdata[ID_BITS + COORD_BITS +: COORD_BITS];
            in_time_reg <= s_tdata[ID_BITS + 2 * COORD_BITS +: TIME_BITS];
        end
    end

    // Result register: control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= fire && res_valid;
        end
    end

    // Result register: payload
    always_ff @(posedge aclk) begin
        if (advance && fire && res_valid) begin
            out_kind_reg    <= res_kind;
            out_id_reg      <= res_id;
            out_end_x_reg   <= res_end_x;
            out_end_y_reg   <= res_end_y;
            out_begin_x_reg <= res_begin_x;
            out_begin_y_reg <= res_begin_y;
            out_delta_x_reg <= res_delta_x;
            out_delta_y_reg <= res_delta_y;
            out_time_reg    <= in_time_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = OUT_DW'({out_time_reg, out_delta_y_reg, out_delta_x_reg,
                               out_begin_y_reg, out_begin_x_reg, out_end_y_reg,
                               out_end_x_reg, out_id_reg});

`ifndef NO_ASSERTIONS
    // A waiting event is never dropped while the result side is stalled
    a_event_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_time_reg))
        else $error("pending event lost during stall");

    // Hold beats carry no displacement
    a_hold_no_delta: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_kind_reg == KIND_HOLD
            |-> out_delta_x_reg == '0 && out_delta_y_reg == '0)
        else $error("hold beat with nonzero delta");

    // Other beats carry end minus begin
    a_delta_match: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_kind_reg != KIND_HOLD
            |-> out_delta_x_reg == ({1'b0, out_end_x_reg} - {1'b0, out_begin_x_reg})
             && out_delta_y_reg == ({1'b0, out_end_y_reg} - {1'b0, out_begin_y_reg}))
        else $error("delta does not match end minus begin");
`endif

endmodule

`default_nettype wire

FILE: tb/sv/touch_gesture_recognizer_tb.sv
// Self-checking testbench for the touch gesture recognizer: predicted gestures vs. result beats.
`default_nettype none

module touch_gesture_recognizer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tgr_pkg::*;

    localparam int IN_BITS     = 64;   // id 4, x 12, y 12, ms 32, padded
    localparam int OUT_BITS    = 112;  // id, end xy, begin xy, delta xy, ms, padded
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLDOFF_LEN = 300;
    localparam int PHASE_EVENTS = 155;

    // One predicted gesture beat
    typedef struct {
        kind_t     kind;
        bit [3:0]  id;
        bit [11:0] end_x;
        bit [11:0] end_y;
        bit [11:0] begin_x;
        bit [11:0] begin_y;
        bit [12:0] delta_x;
        bit [12:0] delta_y;
        bit [31:0] stamp;
    } gesture_t;

    // Tracks the single active press and the last tap, queues the gestures they produce
    class gesture_tracker;
        bit [11:0] slop;
        bit [11:0] swipe;
        bit [15:0] tap_tmo;
        bit [15:0] dtap_win;
        bit [15:0] hold_ms;
        bit        pressed;
        bit        hold_done;
        bit [3:0]  owner;
        bit [11:0] org_x, org_y, last_x, last_y;
        bit [31:0] press_ms;
        bit [31:0] tap_ms;
        bit [11:0] tap_x, tap_y;
        gesture_t  pending_gestures[$];
        int unsigned mismatches;
        int unsigned kind_seen[4];

        function new();
            slop     = TAP_SLOP_RST;
            swipe    = SWIPE_LEN_RST;
            tap_tmo  = TAP_TIMEOUT_RST;
            dtap_win = DTAP_WINDOW_RST;
            hold_ms  = HOLD_TIME_RST;
        endfunction

        function void write_reg(cfg_addr_t addr, bit [15:0] value);
            case (addr)
                CFG_TAP_SLOP:    slop     = value[11:0];
                CFG_SWIPE_LEN:   swipe    = value[11:0];
                CFG_TAP_TIMEOUT: tap_tmo  = value;
                CFG_DTAP_WINDOW: dtap_win = value;
                CFG_HOLD_TIME:   hold_ms  = value;
                default: ;
            endcase
        endfunction

        // Chebyshev distance
        function int spread(bit [11:0] ax, bit [11:0] ay, bit [11:0] bx, bit [11:0] by);
            int dx, dy;
            dx = (ax > bx) ? ax - bx : bx - ax;
            dy = (ay > by) ? ay - by : by - ay;
            return (dx > dy) ? dx : dy;
        endfunction

        function void add(kind_t kind, bit [3:0] id, bit [11:0] ex, bit [11:0] ey,
                          bit with_delta, bit [31:0] now);
            gesture_t g;
            g.kind    = kind;
            g.id      = id;
            g.end_x   = ex;
            g.end_y   = ey;
            g.begin_x = org_x;
            g.begin_y = org_y;
            g.delta_x = with_delta ? {1'b0, ex} - {1'b0, org_x} : 13'd0;
            g.delta_y = with_delta ? {1'b0, ey} - {1'b0, org_y} : 13'd0;
            g.stamp   = now;
            pending_gestures.push_back(g);
        endfunction

        // Advance the press state by one accepted event beat
        function void note_event(op_t op, bit [3:0] id, bit [11:0] x, bit [11:0] y,
                                 bit [31:0] now);
            bit        owns;
            bit        dbl;
            int        span;
            bit [31:0] elapsed;
            owns = pressed && owner == id;
            case (op)
                OP_DOWN: if (!pressed) begin
                    pressed   = 1'b1;
                    hold_done = 1'b0;
                    owner     = id;
                    org_x     = x;
                    org_y     = y;
                    last_x    = x;
                    last_y    = y;
                    press_ms  = now;
                end
                OP_MOVE: if (owns) begin
                    last_x = x;
                    last_y = y;
                end
                OP_UP: if (owns) begin
                    last_x  = x;
                    last_y  = y;
                    span    = spread(org_x, org_y, x, y);
                    elapsed = now - press_ms;
                    if (span >= int'(swipe)) begin
                        add(KIND_SWIPE, id, x, y, 1'b1, now);
                    end else if (!hold_done && span <= int'(slop) && elapsed <= tap_tmo) begin
                        // a second tap close in time and place makes a double tap
                        dbl = tap_ms != 0 && (now - tap_ms) <= dtap_win &&
                              spread(tap_x, tap_y, x, y) <= int'(slop) * 2;
                        add(dbl ? KIND_DOUBLE : KIND_TAP, id, x, y, 1'b1, now);
                        if (dbl) begin
                            tap_ms = 0;
                        end else begin
                            tap_ms = now;
                            tap_x  = x;
                            tap_y  = y;
                        end
                    end
                    pressed   = 1'b0;
                    hold_done = 1'b0;
                end
                OP_TICK: begin
                    if (pressed && !hold_done && (now - press_ms) >= hold_ms &&
                        spread(org_x, org_y, last_x, last_y) <= int'(slop)) begin
                        add(KIND_HOLD, owner, last_x, last_y, 1'b0, now);
                        hold_done = 1'b1;
                    end
                end
            endcase
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
                mismatches++;
            end
        endfunction

        // Compare one result beat with the oldest prediction
        function void check_gesture(logic [1:0] kind, logic [OUT_BITS-1:0] data);
            gesture_t g;
            if (pending_gestures.size() == 0) begin
                $display("%0t: unexpected gesture, expected none, actual kind %0h data %0h",
                         $time, kind, data);
                mismatches++;
                return;
            end
            g = pending_gestures.pop_front();
            kind_seen[g.kind]++;
            compare_field("gesture_kind", g.kind,    kind);
            compare_field("slot",         g.id,      data[3:0]);
            compare_field("end_x",        g.end_x,   data[15:4]);
            compare_field("end_y",        g.end_y,   data[27:16]);
            compare_field("begin_x",      g.begin_x, data[39:28]);
            compare_field("begin_y",      g.begin_y, data[51:40]);
            compare_field("delta_x",      g.delta_x, data[64:52]);
            compare_field("delta_y",      g.delta_y, data[77:65]);
            compare_field("event_time",   g.stamp,   data[109:78]);
        endfunction
    endclass

    logic                     aclk      = 1'b0;
    logic                     aresetn   = 1'b0;
    logic                     s_tvalid  = 1'b0;
    logic                     s_tready;
    logic [IN_BITS-1:0]       s_tdata   = '0;   // contact_id, pos_x, pos_y, now_ms
    logic [1:0]               s_tuser   = OP_DOWN; // op
    logic                     m_tvalid;
    logic                     m_tready  = 1'b0;
    logic [OUT_BITS-1:0]      m_tdata;  // id, end_x, end_y, begin_x, begin_y, dx, dy, time
    logic [1:0]               m_tuser;  // gesture_kind
    logic                     cfg_we    = 1'b0;
    logic [CFG_ADDR_BITS-1:0] cfg_addr  = CFG_TAP_SLOP;
    logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;

    gesture_tracker tracker;
    int unsigned    tx_idle_pct  = 0;
    int unsigned    rx_stall_pct = 0;
    logic           holdoff_req  = 1'b0;
    int unsigned    holdoff_left = 0;
    int unsigned    cycle_count  = 0;
    int unsigned    stall_cycles = 0;
    int unsigned    events_sent  = 0;
    bit [31:0]      clock_ms     = 32'd50;
    // thresholds currently loaded, used to shape the stimulus
    bit [11:0]      cur_slop     = TAP_SLOP_RST;
    bit [11:0]      cur_swipe    = SWIPE_LEN_RST;
    bit [15:0]      cur_tmo      = TAP_TIMEOUT_RST;
    bit [15:0]      cur_win      = DTAP_WINDOW_RST;
    bit [15:0]      cur_hold     = HOLD_TIME_RST;

    touch_gesture_recognizer uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #10 aclk = ~aclk;

    // Watchdog and input backpressure count
    always @(posedge aclk) begin
        cycle_count++;
        if (aresetn && s_tvalid && !s_tready)
            stall_cycles++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Result side: check each beat, then pick the next tready
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            tracker.check_gesture(m_tuser, m_tdata);
        if (holdoff_req) begin
            holdoff_left = HOLDOFF_LEN;
            holdoff_req <= 1'b0;
        end
        if (holdoff_left > 0) begin
            holdoff_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Present one event beat and wait for it to be taken
    task automatic send_event(op_t op, bit [3:0] id, bit [11:0] x, bit [11:0] y,
                              bit [31:0] now);
        if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < tx_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'd0, now, y, x, id};
        do @(posedge aclk); while (!s_tready);
        tracker.note_event(op, id, x, y, now);
        events_sent++;
    endtask

    // Stop sending, wait for all predicted gestures, then let the pipeline settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (tracker.pending_gestures.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic load_thresholds(bit [11:0] slop, bit [11:0] swipe, bit [15:0] tmo,
                                   bit [15:0] win, bit [15:0] hold);
        cfg_addr_t regs[5];
        bit [15:0] vals[5];
        regs = '{CFG_TAP_SLOP, CFG_SWIPE_LEN, CFG_TAP_TIMEOUT, CFG_DTAP_WINDOW, CFG_HOLD_TIME};
        vals = '{{4'd0, slop}, {4'd0, swipe}, tmo, win, hold};
        for (int i = 0; i < 5; i++) begin
            cfg_we    <= 1'b1;
            cfg_addr  <= regs[i];
            cfg_wdata <= vals[i];
            @(posedge aclk);
            tracker.write_reg(regs[i], vals[i]);
        end
        cfg_we    <= 1'b0;
        cur_slop  = slop;
        cur_swipe = swipe;
        cur_tmo   = tmo;
        cur_win   = win;
        cur_hold  = hold;
    endtask

    // Random point within r pixels of c on the screen
    function automatic bit [11:0] nudge(bit [11:0] c, int unsigned r);
        int v;
        v = int'(c) + int'($urandom_range(2 * r)) - int'(r);
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
        return v[11:0];
    endfunction

    // Point d pixels away from c along one axis, or 4095 when neither direction fits
    function automatic bit [11:0] reach(bit [11:0] c, int unsigned d);
        if (int'(c) + int'(d) <= 4095) return c + d[11:0];
        if (int'(c) >= int'(d)) return c - d[11:0];
        return 12'd4095;
    endfunction

    function automatic bit [31:0] tap_length();
        if ($urandom_range(4) == 0) return cur_tmo + $urandom_range(1, 100);
        return $urandom_range(0, cur_tmo);
    endfunction

    // One random gesture: mostly well-formed, some broken, some noise
    task automatic random_gesture();
        int unsigned pick, n;
        bit [3:0]    id, other;
        bit [11:0]   x0, y0, x, y;
        pick  = $urandom_range(99);
        id    = 4'($urandom_range(15));
        other = id ^ 4'($urandom_range(1, 15));
        x0    = 12'($urandom_range(4095));
        y0    = 12'($urandom_range(4095));
        case ($urandom_range(39))
            0: clock_ms = $urandom();
            1: clock_ms = 32'hFFFF_FFFF - $urandom_range(600);
            default: clock_ms += $urandom_range(1, 1500);
        endcase
        if (pick < 45) begin
            // single tap, or two in a row for a double tap
            n = (pick < 20) ? 1 : 2;
            repeat (n) begin
                send_event(OP_DOWN, id, x0, y0, clock_ms);
                if ($urandom_range(1))
                    send_event(OP_MOVE, id, nudge(x0, cur_slop), nudge(y0, cur_slop),
                               clock_ms + 1);
                clock_ms += tap_length();
                send_event(OP_UP, id, nudge(x0, cur_slop), nudge(y0, cur_slop), clock_ms);
                clock_ms += $urandom_range(0, cur_win + 50);
                x0 = nudge(x0, cur_slop);
                y0 = nudge(y0, cur_slop);
            end
        end else if (pick < 62) begin
            // swipe
            send_event(OP_DOWN, id, x0, y0, clock_ms);
            repeat ($urandom_range(2)) begin
                clock_ms += $urandom_range(1, 60);
                send_event(OP_MOVE, id, 12'($urandom_range(4095)), 12'($urandom_range(4095)),
                           clock_ms);
            end
            n = $urandom_range(cur_swipe, 4095);
            if ($urandom_range(1)) begin
                x = reach(x0, n);
                y = nudge(y0, n);
            end else begin
                x = nudge(x0, n);
                y = reach(y0, n);
            end
            clock_ms += $urandom_range(1, 400);
            send_event(OP_UP, id, x, y, clock_ms);
        end else if (pick < 78) begin
            // press and hold, ticks crossing the hold time
            send_event(OP_DOWN, id, x0, y0, clock_ms);
            repeat ($urandom_range(1, 4)) begin
                clock_ms += $urandom_range(0, cur_hold / 2 + 20);
                if ($urandom_range(2) == 0)
                    send_event(OP_MOVE, id,
                               nudge(x0, cur_slop + ($urandom_range(3) == 0 ? 30 : 0)),
                               nudge(y0, cur_slop), clock_ms);
                send_event(OP_TICK, 4'($urandom_range(15)), 12'($urandom_range(4095)),
                           12'($urandom_range(4095)), clock_ms);
            end
            clock_ms += $urandom_range(0, 200);
            send_event(OP_UP, id, nudge(x0, cur_slop), nudge(y0, cur_slop), clock_ms);
        end else if (pick < 90) begin
            // another contact interferes; sometimes the owner never lifts
            send_event(OP_DOWN, id, x0, y0, clock_ms);
            repeat ($urandom_range(2, 4)) begin
                clock_ms += $urandom_range(0, 100);
                send_event(op_t'($urandom_range(2)), other, 12'($urandom_range(4095)),
                           12'($urandom_range(4095)), clock_ms);
            end
            if ($urandom_range(1))
                send_event(OP_UP, id, nudge(x0, cur_slop), nudge(y0, cur_slop),
                           clock_ms + $urandom_range(0, 300));
        end else begin
            // noise
            repeat ($urandom_range(1, 3))
                send_event(op_t'($urandom_range(3)), 4'($urandom_range(15)),
                           12'($urandom_range(4095)), 12'($urandom_range(4095)),
                           $urandom_range(1) ? clock_ms : $urandom());
        end
    endtask

    task automatic run_phase(int unsigned quota);
        int unsigned first;
        first = events_sent;
        while (events_sent - first < quota)
            random_gesture();
        drain();
    endtask

    initial begin
        tracker = new();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed cases with reset thresholds
        send_event(OP_DOWN, 4'd3, 12'd100, 12'd100, 32'd1000);
        send_event(OP_UP,   4'd3, 12'd105, 12'd98,  32'd1100);     // tap
        send_event(OP_DOWN, 4'd3, 12'd110, 12'd100, 32'd1300);
        send_event(OP_UP,   4'd3, 12'd100, 12'd100, 32'd1400);     // double tap
        send_event(OP_DOWN, 4'd0, 12'd0,   12'd0,   32'd2000);
        send_event(OP_DOWN, 4'd5, 12'd50,  12'd50,  32'd2010);     // down while pressed
        send_event(OP_MOVE, 4'd5, 12'd4095, 12'd4095, 32'd2020);   // not the owner
        send_event(OP_UP,   4'd5, 12'd4095, 12'd4095, 32'd2025);   // not the owner
        send_event(OP_MOVE, 4'd0, 12'd4095, 12'd4095, 32'd2030);
        send_event(OP_UP,   4'd0, 12'd4095, 12'd4095, 32'd2040);   // full-screen swipe
        send_event(OP_TICK, 4'd0, 12'd0,   12'd0,   32'd2050);     // tick while released
        send_event(OP_DOWN, 4'd15, 12'd4095, 12'd0, 32'd3000);
        send_event(OP_TICK, 4'd0, 12'd0,   12'd0,   32'd3500);     // too early
        send_event(OP_TICK, 4'd9, 12'd7,   12'd7,   32'd3650);     // hold, exactly on time
        send_event(OP_TICK, 4'd15, 12'd0,  12'd0,   32'd3700);     // hold already reported
        send_event(OP_UP,   4'd15, 12'd4090, 12'd5, 32'd3700);     // ends silently
        send_event(OP_DOWN, 4'd2, 12'd0,   12'd4095, 32'hFFFF_FF00);
        send_event(OP_UP,   4'd2, 12'd0,   12'd4095, 32'h0000_0000); // tap at time zero
        send_event(OP_DOWN, 4'd2, 12'd0,   12'd4095, 32'd100);
        send_event(OP_UP,   4'd2, 12'd0,   12'd4095, 32'd200);     // no prior tap: tap
        send_event(OP_DOWN, 4'd7, 12'd2000, 12'd2000, 32'd5000);
        send_event(OP_MOVE, 4'd7, 12'd2030, 12'd2000, 32'd5050);
        send_event(OP_UP,   4'd7, 12'd2030, 12'd2000, 32'd5100);   // between slop and swipe
        send_event(OP_DOWN, 4'd1, 12'd10,  12'd10,  32'd6000);
        send_event(OP_UP,   4'd1, 12'd10,  12'd10,  32'd6400);     // press too long
        run_phase(PHASE_EVENTS);

        // moderate thresholds, sender idles
        tx_idle_pct  = 49;
        rx_stall_pct = 0;
        load_thresholds(12'($urandom_range(5, 60)), 12'($urandom_range(70, 300)),
                        16'($urandom_range(100, 1000)), 16'($urandom_range(100, 1000)),
                        16'($urandom_range(200, 2000)));
        run_phase(PHASE_EVENTS);

        // all thresholds zero, receiver stalls
        tx_idle_pct  = 0;
        rx_stall_pct = 49;
        load_thresholds(12'd0, 12'd0, 16'd0, 16'd0, 16'd0);
        run_phase(PHASE_EVENTS);

        // all thresholds at maximum, both sides idle
        tx_idle_pct  = 23;
        rx_stall_pct = 23;
        load_thresholds(12'hFFF, 12'hFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_phase(PHASE_EVENTS);

        // random thresholds, receiver held off while events keep coming
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        load_thresholds(12'($urandom_range(4095)), 12'($urandom_range(4095)),
                        16'($urandom_range(65535)), 16'($urandom_range(65535)),
                        16'($urandom_range(65535)));
        holdoff_req <= 1'b1;
        run_phase(PHASE_EVENTS);

        // back to default thresholds, sender idles
        tx_idle_pct  = 49;
        rx_stall_pct = 0;
        load_thresholds(TAP_SLOP_RST, SWIPE_LEN_RST, TAP_TIMEOUT_RST, DTAP_WINDOW_RST,
                        HOLD_TIME_RST);
        run_phase(PHASE_EVENTS);

        if (tracker.pending_gestures.size() != 0) begin
            $display("%0t: %0d predicted gestures never arrived", $time,
                     tracker.pending_gestures.size());
            tracker.mismatches++;
        end
        $display("covered %0d events over six threshold settings; input stalled %0d cycles",
                 events_sent, stall_cycles);
        $display("gestures seen: swipe %0d, tap %0d, double tap %0d, hold %0d; mismatches %0d",
                 tracker.kind_seen[KIND_SWIPE], tracker.kind_seen[KIND_TAP],
                 tracker.kind_seen[KIND_DOUBLE], tracker.kind_seen[KIND_HOLD],
                 tracker.mismatches);
        if (tracker.mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

`default_nettype wire
